### sv/m97_pkg.sv
// Shared types, constants and arithmetic helpers for the mod-97 address checker.
// No dependencies; every other file in this block imports this package.
package m97_pkg;

    // Geometry of the address string.
    localparam int unsigned TOTAL_LEN   = 36;
    localparam int unsigned LEN_SAT     = 37;
    localparam int unsigned BODY_START  = 4;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Checksum constants.
    localparam logic [6:0] CHECK_BASE = 7'd98;
    // 10^6 mod 97 and 232600 mod 97, so the final append is rem*27 + 91.
    localparam logic [4:0] SHIFT6_MOD = 5'd27;
    localparam logic [6:0] PREFIX_MOD = 7'd91;
    localparam logic [6:0] MODULUS    = 7'd97;
    // Reciprocal of 97 scaled by 2^20, rounded up; exact for inputs below 11522,
    // which covers every body fold (at most 9634) and the final append.
    localparam logic [13:0] RECIP_97  = 14'd10811;
    localparam int unsigned RECIP_SH  = 20;

    // Characters that the checker looks for.
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Error codes, in priority order.
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_PREFIX   = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_ALPHABET = 3'd3;
    localparam logic [2:0] ERR_DIGITS   = 3'd4;
    localparam logic [2:0] ERR_CHECKSUM = 3'd5;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic       is_last;
        logic       is_space;
        logic       is_n;
        logic       is_q;
        logic       is_digit;
        logic [3:0] digit_val;
        logic       sym_ok;
        logic       sym_big;
        logic [5:0] sym_val;
    } m97_token_t;

    // Everything the finish stage needs from one completed string.
    typedef struct packed {
        logic       prefix_fail;
        logic [5:0] kept;
        logic       alpha_bad;
        logic       digits_bad;
        logic [6:0] given;
        logic [6:0] rem;
    } m97_summary_t;

    // Remainder modulo 97 of a value below 11522, by reciprocal multiplication.
    function automatic logic [6:0] mod97(input logic [13:0] x);
        logic [27:0] prod;
        logic [7:0]  quot;
        logic [14:0] back;
        logic [13:0] diff;
        prod = x * RECIP_97;
        quot = prod[RECIP_SH +: 8];
        back = quot * MODULUS;
        diff = x - back[13:0];
        return diff[6:0];
    endfunction

endpackage

### sv/m97_front.sv
// Front end of the mod-97 address checker: accepts characters and classifies them.
// Depends on m97_pkg for the token type and character constants.
module m97_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_code,
    input  logic                s_is_last,
    input  logic                q_full,
    output logic                q_push,
    output m97_pkg::m97_token_t q_token
);
    import m97_pkg::*;

    logic       digit;
    logic       letter_ok;
    logic [7:0] letter_val;

    // A transaction is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Letters of the alphabet: A-H, J-N, P-V, X, Y (no I, O, W, Z).
    always_comb begin
        digit      = (s_char_code >= CH_ZERO) && (s_char_code <= CH_NINE);
        letter_ok  = ((s_char_code >= 8'h41) && (s_char_code <= 8'h48)) ||
                     ((s_char_code >= 8'h4A) && (s_char_code <= 8'h4E)) ||
                     ((s_char_code >= 8'h50) && (s_char_code <= 8'h56)) ||
                     (s_char_code == 8'h58) || (s_char_code == 8'h59);
        letter_val = s_char_code - CH_SEVEN;
    end

    // Build the classified token.
    always_comb begin
        q_token.is_last   = s_is_last;
        q_token.is_space  = (s_char_code == CH_SPACE);
        q_token.is_n      = (s_char_code == CH_N);
        q_token.is_q      = (s_char_code == CH_Q);
        q_token.is_digit  = digit;
        q_token.digit_val = 4'(s_char_code - CH_ZERO);
        q_token.sym_ok    = digit || letter_ok;
        q_token.sym_big   = letter_ok;
        q_token.sym_val   = digit ? {2'b00, q_token.digit_val} : letter_val[5:0];
    end

endmodule

### sv/m97_queue.sv
// Short first-in first-out queue of classified tokens between front and back.
// Depends on m97_pkg for the token type.
module m97_queue #(
    parameter int unsigned DEPTH = m97_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  m97_pkg::m97_token_t push_token,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output m97_pkg::m97_token_t head_token
);
    import m97_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    m97_token_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_token = mem[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

endmodule

### sv/m97_back.sv
// Back end of the mod-97 address checker: per-string state and the mod-97 fold.
// Depends on m97_pkg for the token and summary types and the mod97 helper.
module m97_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tok_valid,
    input  m97_pkg::m97_token_t   tok,
    output logic                  tok_pop,
    output logic                  sum_valid,
    output m97_pkg::m97_summary_t sum,
    input  logic                  sum_take
);
    import m97_pkg::*;

    logic [1:0]   raw_pos_reg, raw_pos_next;
    logic [5:0]   kept_reg, kept_next;
    logic [6:0]   rem_reg, rem_next;
    logic [6:0]   given_reg, given_next;
    logic         prefix_bad_reg, prefix_bad_next;
    logic         alpha_bad_reg, alpha_bad_next;
    logic         digits_bad_reg, digits_bad_next;
    logic         sum_valid_reg;
    m97_summary_t sum_reg;
    m97_summary_t sum_next;
    logic         sum_free;
    logic [10:0]  given_wide;
    logic [13:0]  fold_in;

    // A last token may only move on when the summary slot is free.
    assign sum_free  = !sum_valid_reg || sum_take;
    assign tok_pop   = tok_valid && (!tok.is_last || sum_free);
    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    // Running digit value and remainder fold for the current character.
    always_comb begin
        given_wide = given_reg * 4'd10 + {7'd0, tok.digit_val};
        fold_in    = rem_reg * (tok.sym_big ? 7'd100 : 7'd10) + {8'd0, tok.sym_val};
    end

    // State update for one character.
    always_comb begin
        raw_pos_next    = raw_pos_reg;
        kept_next       = kept_reg;
        rem_next        = rem_reg;
        given_next      = given_reg;
        prefix_bad_next = prefix_bad_reg;
        alpha_bad_next  = alpha_bad_reg;
        digits_bad_next = digits_bad_reg;

        if ((raw_pos_reg == 2'd0 && !tok.is_n) || (raw_pos_reg == 2'd1 && !tok.is_q)) begin
            prefix_bad_next = 1'b1;
        end
        if (raw_pos_reg != 2'd2) begin
            raw_pos_next = raw_pos_reg + 1'b1;
        end

        if (!tok.is_space) begin
            if (kept_reg == 6'd2 || kept_reg == 6'd3) begin
                if (tok.is_digit) begin
                    given_next = given_wide[6:0];
                end else begin
                    digits_bad_next = 1'b1;
                end
            end else if (kept_reg >= 6'(BODY_START) && kept_reg < 6'(TOTAL_LEN)) begin
                if (tok.sym_ok) begin
                    rem_next = mod97(fold_in);
                end else begin
                    alpha_bad_next = 1'b1;
                end
            end
            if (kept_reg != 6'(LEN_SAT)) begin
                kept_next = kept_reg + 1'b1;
            end
        end

        sum_next.prefix_fail = prefix_bad_next || (raw_pos_next != 2'd2);
        sum_next.kept        = kept_next;
        sum_next.alpha_bad   = alpha_bad_next;
        sum_next.digits_bad  = digits_bad_next;
        sum_next.given       = given_next;
        sum_next.rem         = rem_next;
    end

    // Per-string state; a last token hands its summary over and clears it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_pos_reg    <= '0;
            kept_reg       <= '0;
            rem_reg        <= '0;
            given_reg      <= '0;
            prefix_bad_reg <= 1'b0;
            alpha_bad_reg  <= 1'b0;
            digits_bad_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (tok_pop) begin
                if (tok.is_last) begin
                    raw_pos_reg    <= '0;
                    kept_reg       <= '0;
                    rem_reg        <= '0;
                    given_reg      <= '0;
                    prefix_bad_reg <= 1'b0;
                    alpha_bad_reg  <= 1'b0;
                    digits_bad_reg <= 1'b0;
                end else begin
                    raw_pos_reg    <= raw_pos_next;
                    kept_reg       <= kept_next;
                    rem_reg        <= rem_next;
                    given_reg      <= given_next;
                    prefix_bad_reg <= prefix_bad_next;
                    alpha_bad_reg  <= alpha_bad_next;
                    digits_bad_reg <= digits_bad_next;
                end
            end
            if (tok_pop && tok.is_last) begin
                sum_valid_reg <= 1'b1;
            end else if (sum_take) begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    // Summary payload needs no reset.
    always_ff @(posedge aclk) begin
        if (tok_pop && tok.is_last) begin
            sum_reg <= sum_next;
        end
    end

endmodule

### sv/m97_finish.sv
// Finish stage of the mod-97 address checker: final append, error priority, result register.
// Depends on m97_pkg for the summary type, error codes and the mod97 helper.
module m97_finish (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  sum_valid,
    input  m97_pkg::m97_summary_t sum,
    output logic                  sum_take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_valid_res,
    output logic [2:0]            m_error_code,
    output logic [6:0]            m_computed_check
);
    import m97_pkg::*;

    logic        m_valid_reg;
    logic        res_reg;
    logic [2:0]  err_reg, err_next;
    logic [6:0]  check_reg, check_next;
    logic [11:0] append;
    logic [6:0]  fin;
    logic [6:0]  computed;
    logic        out_free;

    assign out_free         = !m_valid_reg || m_ready;
    assign sum_take         = sum_valid && out_free;
    assign m_valid          = m_valid_reg;
    assign m_valid_res      = res_reg;
    assign m_error_code     = err_reg;
    assign m_computed_check = check_reg;

    // Append the prefix constant and form the check value.
    always_comb begin
        append   = sum.rem * SHIFT6_MOD + {5'd0, PREFIX_MOD};
        fin      = mod97({2'b00, append});
        computed = CHECK_BASE - fin;
    end

    // First failing check wins.
    always_comb begin
        if (sum.prefix_fail) begin
            err_next = ERR_PREFIX;
        end else if (sum.kept != 6'(TOTAL_LEN)) begin
            err_next = ERR_LENGTH;
        end else if (sum.alpha_bad) begin
            err_next = ERR_ALPHABET;
        end else if (sum.digits_bad) begin
            err_next = ERR_DIGITS;
        end else if (sum.given != computed) begin
            err_next = ERR_CHECKSUM;
        end else begin
            err_next = ERR_OK;
        end
        if (err_next == ERR_PREFIX || err_next == ERR_LENGTH || err_next == ERR_ALPHABET) begin
            check_next = '0;
        end else begin
            check_next = computed;
        end
    end

    // Result register; it refills in the cycle the receiver takes the old result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_take) begin
            res_reg   <= (err_next == ERR_OK);
            err_reg   <= err_next;
            check_reg <= check_next;
        end
    end

endmodule

### sv/mod97_base32_address_validator.sv
// Top level of the mod-97 address checker: front, token queue, back and finish stage.
// Depends on m97_pkg, m97_front, m97_queue, m97_back and m97_finish.
//
// Usage: the address string arrives one character per transaction on the s_
// channel (s_char_code, s_is_last). Exactly one result transaction leaves on
// the m_ channel for each character marked last; other characters give none.
// The result carries m_valid_res, m_error_code (0 ok, 1 prefix, 2 length,
// 3 alphabet, 4 check digits, 5 checksum) and m_computed_check.
// Throughput: one character per cycle while the receiver keeps taking results;
// each body character passes through the single mod-97 fold in the back end.
// Path: a last character passes through the queue entry, the back-end summary
// register and the finish register before its result is shown on m_valid.
// Reset (aresetn low, synchronous) empties the queue, clears all string
// state and drops m_valid. When the receiver holds off m_ready, the result
// waits in the output register, one more summary waits in the back end, and
// characters keep flowing into the queue until it is full; s_ready then falls.
module mod97_base32_address_validator #(
    parameter int unsigned QUEUE_DEPTH = m97_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_valid_res,
    output logic [2:0] m_error_code,
    output logic [6:0] m_computed_check
);
    import m97_pkg::*;

    logic         q_full;
    logic         q_push;
    m97_token_t   q_in;
    logic         q_pop;
    logic         q_not_empty;
    m97_token_t   q_head;
    logic         sum_valid;
    m97_summary_t sum;
    logic         sum_take;

    // Classify incoming characters.
    m97_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_token     (q_in)
    );

    // Decouple front from back.
    m97_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_token (q_head)
    );

    // Per-string checks and remainder fold.
    m97_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (q_not_empty),
        .tok       (q_head),
        .tok_pop   (q_pop),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_take  (sum_take)
    );

    // Final check value and result register.
    m97_finish u_finish (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .sum_valid        (sum_valid),
        .sum              (sum),
        .sum_take         (sum_take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_valid_res      (m_valid_res),
        .m_error_code     (m_error_code),
        .m_computed_check (m_computed_check)
    );

endmodule

### tb/sv/m97_verdict_checker.sv
// Verdict checker for the mod-97 address validator: watches both channels,
// predicts each result from the accepted characters and compares field by field.
// Depends on m97_pkg for the error codes.
module m97_verdict_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_is_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_valid_res,
    input  logic [2:0] m_error_code,
    input  logic [6:0] m_computed_check,
    output int         mismatch_count,
    output int         pending_verdicts,
    output int         verdicts_checked,
    output int         verdicts_passed
);
    import m97_pkg::*;

    // Address geometry and checksum constants.
    localparam int ADDR_LEN     = 36;
    localparam int KEPT_CAP     = 37;
    localparam int BODY_FIRST   = 4;
    localparam int CHECK_MOD    = 97;
    localparam int CHECK_OFFSET = 98;
    localparam int PREFIX_TAIL  = 232600;

    typedef struct {
        logic       valid_res;
        logic [2:0] error_code;
        logic [6:0] computed_check;
    } verdict_t;

    verdict_t   verdict_q[$];
    verdict_t   oldest;
    int         bad_count;
    int         seen_count;
    int         pass_count;

    // Predicted string state.
    logic [1:0] raw_pos;
    logic [5:0] kept;
    logic [6:0] body_rem;
    logic [6:0] digits_val;
    logic       prefix_fail;
    logic       alpha_fail;
    logic       digit_fail;

    initial begin
        bad_count  = 0;
        seen_count = 0;
        pass_count = 0;
    end

    // Value of a body symbol, or -1 when the character is outside the alphabet.
    function automatic int symbol_weight(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'(8'h30);
        end
        if (c < "A" || c > "Y" || c == "I" || c == "O" || c == "W") begin
            return -1;
        end
        return int'(c) - int'(8'h37);
    endfunction

    task automatic clear_string();
        raw_pos     = '0;
        kept        = '0;
        body_rem    = '0;
        digits_val  = '0;
        prefix_fail = 1'b0;
        alpha_fail  = 1'b0;
        digit_fail  = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        bad_count++;
    endtask

    // Fold one accepted character into the string state; a last character
    // closes the string and queues its verdict.
    task automatic absorb_char(input logic [7:0] c, input logic last);
        int         w;
        int         fin;
        int         chk;
        logic [2:0] err;
        verdict_t   v;
        if (raw_pos == 2'd0 && c != "N") prefix_fail = 1'b1;
        if (raw_pos == 2'd1 && c != "Q") prefix_fail = 1'b1;
        if (raw_pos < 2'd2) raw_pos++;

        if (c != " ") begin
            if (kept == 6'd2 || kept == 6'd3) begin
                if (c >= "0" && c <= "9") begin
                    w = (int'(digits_val) * 10 + int'(c) - int'(8'h30)) & 127;
                    digits_val = w[6:0];
                end else begin
                    digit_fail = 1'b1;
                end
            end else if (kept >= BODY_FIRST && kept < ADDR_LEN) begin
                w = symbol_weight(c);
                if (w < 0) begin
                    alpha_fail = 1'b1;
                end else begin
                    fin = (int'(body_rem) * ((w < 10) ? 10 : 100) + w) % CHECK_MOD;
                    body_rem = fin[6:0];
                end
            end
            if (kept < KEPT_CAP) kept++;
        end

        if (last) begin
            fin = (int'(body_rem) * 1000000 + PREFIX_TAIL) % CHECK_MOD;
            chk = CHECK_OFFSET - fin;
            if (prefix_fail || raw_pos < 2'd2) begin
                err = ERR_PREFIX;
            end else if (kept != ADDR_LEN) begin
                err = ERR_LENGTH;
            end else if (alpha_fail) begin
                err = ERR_ALPHABET;
            end else if (digit_fail) begin
                err = ERR_DIGITS;
            end else if (digits_val != chk[6:0]) begin
                err = ERR_CHECKSUM;
            end else begin
                err = ERR_OK;
            end
            v.valid_res      = (err == ERR_OK);
            v.error_code     = err;
            v.computed_check = (err == ERR_PREFIX || err == ERR_LENGTH
                                || err == ERR_ALPHABET) ? 7'd0 : chk[6:0];
            verdict_q.push_back(v);
            clear_string();
        end
    endtask

    // Compare a result transaction with the oldest predicted verdict.
    task automatic check_result();
        if (verdict_q.size() == 0) begin
            report_mismatch("result transaction with no string pending");
        end else begin
            oldest = verdict_q.pop_front();
            seen_count++;
            if (m_valid_res !== oldest.valid_res) begin
                report_mismatch($sformatf("result %0d: valid_res %b, predicted %b",
                                          seen_count, m_valid_res, oldest.valid_res));
            end
            if (m_error_code !== oldest.error_code) begin
                report_mismatch($sformatf("result %0d: error_code %0d, predicted %0d",
                                          seen_count, m_error_code, oldest.error_code));
            end
            if (m_computed_check !== oldest.computed_check) begin
                report_mismatch($sformatf("result %0d: computed_check %0d, predicted %0d",
                                          seen_count, m_computed_check,
                                          oldest.computed_check));
            end
            if (m_valid_res === 1'b1) pass_count++;
        end
    endtask

    // Sample both channels at each edge; counts are published a step later.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_string();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) absorb_char(s_char_code, s_is_last);
        end
        mismatch_count   <= bad_count;
        pending_verdicts <= verdict_q.size();
        verdicts_checked <= seen_count;
        verdicts_passed  <= pass_count;
    end

endmodule

### tb/sv/tb_mod97_base32_address_validator.sv
// Testbench top for mod97_base32_address_validator: drives address strings
// with random gaps and stalls and gives the verdict from m97_verdict_checker.
// Depends on m97_pkg, the block's RTL and tb/sv/m97_verdict_checker.sv.
module tb_mod97_base32_address_validator;
    import m97_pkg::*;

    localparam logic [8*32-1:0] SYMBOLS = "0123456789ABCDEFGHJKLMNPQRSTUVXY";

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_BAD_PREFIX,
        SHAPE_SPACE_PREFIX,
        SHAPE_BAD_DIGIT,
        SHAPE_SIGN_DIGIT,
        SHAPE_BAD_SYMBOL,
        SHAPE_SHORT,
        SHAPE_LONG,
        SHAPE_NOISE
    } addr_shape_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code = 8'h00;
    logic       s_is_last   = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_valid_res;
    logic [2:0] m_error_code;
    logic [6:0] m_computed_check;

    int         mismatches;
    int         pending;
    int         checked;
    int         passed;

    logic [7:0] addr_q[$];
    bit         calm          = 1'b0;
    int         chars_sent    = 0;
    int         strings_sent  = 0;
    int         random_strings = 0;

    mod97_base32_address_validator u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_valid_res      (m_valid_res),
        .m_error_code     (m_error_code),
        .m_computed_check (m_computed_check)
    );

    m97_verdict_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_valid_res      (m_valid_res),
        .m_error_code     (m_error_code),
        .m_computed_check (m_computed_check),
        .mismatch_count   (mismatches),
        .pending_verdicts (pending),
        .verdicts_checked (checked),
        .verdicts_passed  (passed)
    );

    // Clock.
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Result side: a random stall before each transaction, none when calm.
    initial begin : result_drain
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // One character transaction after a random idle gap.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    task automatic send_string();
        int k;
        for (k = 0; k < addr_q.size(); k++) begin
            send_char(addr_q[k], k == addr_q.size() - 1);
        end
        strings_sent++;
    endtask

    // Short literal string, leftmost character first.
    task automatic send_text(input logic [63:0] txt, input int n);
        int k;
        addr_q.delete();
        for (k = 0; k < n; k++) begin
            addr_q.push_back(txt[8*(n-1-k) +: 8]);
        end
        send_string();
    endtask

    // Build a well-formed address with correct check digits, then damage it
    // according to the shape. Noise strings are random bytes instead.
    task automatic build_address(input addr_shape_t shape);
        int         rem;
        int         chk;
        int         idx;
        int         w;
        int         n;
        int         k;
        int         pos;
        logic [7:0] ch;
        addr_q.delete();
        if (shape == SHAPE_NOISE) begin
            n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 45);
            if ($urandom_range(0, 3) == 0) begin
                addr_q.push_back("N");
                addr_q.push_back("Q");
            end
            for (k = 0; k < n; k++) addr_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            addr_q.push_back("N");
            addr_q.push_back("Q");
            addr_q.push_back("0");
            addr_q.push_back("0");
            rem = 0;
            for (k = 0; k < 32; k++) begin
                idx = $urandom_range(0, 31);
                ch  = SYMBOLS[8*(31-idx) +: 8];
                w   = (idx < 10) ? idx : int'(ch) - int'(8'h37);
                rem = (rem * ((w < 10) ? 10 : 100) + w) % 97;
                addr_q.push_back(ch);
            end
            chk = 98 - (rem * 1000000 + 232600) % 97;
            if (shape == SHAPE_BAD_SUM) chk = (chk + $urandom_range(1, 99)) % 100;
            addr_q[2] = 8'(int'(8'h30) + chk / 10);
            addr_q[3] = 8'(int'(8'h30) + chk % 10);

            case (shape)
                SHAPE_BAD_PREFIX: begin
                    pos = $urandom_range(0, 1);
                    do ch = 8'($urandom_range(0, 255)); while (ch == addr_q[pos]);
                    addr_q[pos] = ch;
                end
                SHAPE_SPACE_PREFIX: begin
                    addr_q.insert($urandom_range(0, 1), " ");
                end
                SHAPE_BAD_DIGIT: begin
                    do ch = 8'($urandom_range(0, 255));
                    while ((ch >= "0" && ch <= "9") || ch == " ");
                    addr_q[$urandom_range(2, 3)] = ch;
                end
                SHAPE_SIGN_DIGIT: begin
                    addr_q[2] = $urandom_range(0, 1) ? "+" : "-";
                end
                SHAPE_BAD_SYMBOL: begin
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        case ($urandom_range(0, 5))
                            0:       ch = "I";
                            1:       ch = "O";
                            2:       ch = "W";
                            3:       ch = "Z";
                            4:       ch = 8'($urandom_range("a", "z"));
                            default: ch = 8'($urandom_range(128, 255));
                        endcase
                        addr_q[$urandom_range(4, 35)] = ch;
                    end
                end
                SHAPE_SHORT: begin
                    n = $urandom_range(1, 6);
                    repeat (n) addr_q.delete($urandom_range(2, addr_q.size() - 1));
                end
                SHAPE_LONG: begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        idx = $urandom_range(0, 31);
                        addr_q.insert($urandom_range(2, addr_q.size()),
                                      SYMBOLS[8*(31-idx) +: 8]);
                    end
                end
                default: ;
            endcase

            // Spaces after the prefix are skipped by the block.
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) addr_q.insert($urandom_range(2, addr_q.size()), " ");
            end
        end
    endtask

    // Random strings until both goals are met; the first ten cover every shape.
    task automatic run_strings(input int char_goal, input int string_goal);
        addr_shape_t shape;
        int          r;
        while (chars_sent < char_goal || strings_sent < string_goal) begin
            if (random_strings < 10) begin
                shape = addr_shape_t'(random_strings);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) shape = SHAPE_GOOD;
                else if (r < 50) shape = SHAPE_BAD_SUM;
                else shape = addr_shape_t'($urandom_range(2, 9));
            end
            build_address(shape);
            send_string();
            random_strings++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: byte extremes, short strings, spaces in the prefix and
        // sign or letter characters where check digits belong.
        send_text(64'h00, 1);
        send_text(64'hFF, 1);
        send_text("N", 1);
        send_text("NQ", 2);
        send_text(" NQ", 3);
        send_text("N Q", 3);
        send_text("NQ+7", 4);
        send_text("NQ-5", 4);
        send_text("NQ9A", 4);

        run_strings(650, 0);

        // Hold the sender until every verdict is back, then run back to back.
        wait_drained();
        calm = 1'b1;
        run_strings(900, 0);
        calm = 1'b0;
        run_strings(1250, 48);

        wait_drained();
        repeat (12) @(posedge aclk);

        $display("Sent %0d characters in %0d strings across gapped, %s",
                 chars_sent, strings_sent, "back-to-back and drained phases.");
        $display("Checked %0d verdicts, %0d of them valid addresses.", checked, passed);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### mod97_base32_address_validator.f
sv/m97_pkg.sv
sv/m97_front.sv
sv/m97_queue.sv
sv/m97_back.sv
sv/m97_finish.sv
sv/mod97_base32_address_validator.sv
tb/sv/m97_verdict_checker.sv
tb/sv/tb_mod97_base32_address_validator.sv
